### rtl/wfps_pkg.sv
// ============================================================================
// wfps_pkg: shared types and constants for the watchdog feed pulse scheduler
// Opcodes, register indexes, sequencer states and the remainder unit ports.
// ============================================================================
package wfps_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] INTERVAL_RST = 32'd1000;
    localparam logic [DATA_W-1:0] PULSE_RST    = 32'd10;
    localparam logic              LEVEL_RST    = 1'b1;

    localparam logic [CNT_W-1:0]  BIT_LAST     = CNT_W'(DATA_W - 1);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_POLL  = 2'd1,
        OP_FORCE = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_LEVEL    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SER,
        S_DIV,
        S_ADD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

endpackage

### rtl/watchdog_feed_pulse_scheduler.sv
// ============================================================================
// watchdog_feed_pulse_scheduler: periodic feed pulses for an external watchdog
// Bit-serial sequencer that tracks deadlines on a wrapping millisecond clock.
// ============================================================================
// Usage
//   Input channel (in_valid / in_stall) carries opcode and now_ms; every
//   transfer produces exactly one result transfer on the output channel
//   (out_valid / out_stall) with pin_level, pulse_active, enabled_flag and
//   force_accepted. One item is in flight at a time: in_stall is high from
//   the accepting edge until the result has been taken.
//   Start, force, stop and polls that need no deadline catch-up show
//   out_valid after one serial pass over the operands. A poll that reaches
//   its deadline with no pulse left running adds a pass through the
//   remainder unit and a serial add. The 1-bit serial datapath and the
//   radix-2 remainder unit set the length of these passes. After the result
//   transfer the sequencer returns to idle before it takes the next input.
//   If the receiver stalls, the result holds steady and no input is taken.
//   Reset clears the enable, pulse and pin state (pin reads 0, disabled) and
//   loads the settings 1000 / 10 / active high. Settings are written on the
//   cfg port at any time and only take effect at the next start opcode.
// ============================================================================
module watchdog_feed_pulse_scheduler
    import wfps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [DATA_W-1:0]    now_ms,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 pin_level,
    output logic                 pulse_active,
    output logic                 enabled_flag,
    output logic                 force_accepted
);

    // settings written through the cfg port
    logic [DATA_W-1:0] feed_interval_reg;
    logic [DATA_W-1:0] pulse_width_reg;
    logic              active_high_reg;

    // control state
    state_t            state_reg, state_next;
    logic              pulsing_reg, pulsing_next;
    logic              running_reg, running_next;
    logic              pin_state_reg, pin_state_next;
    logic              accepted_reg, accepted_next;

    // serial datapath: every 32-bit word rotates LSB first
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    opcode_t           op_reg, op_next;
    logic [DATA_W-1:0] now_reg, now_next;
    logic [DATA_W-1:0] began_reg, began_next;
    logic [DATA_W-1:0] deadline_reg, deadline_next;
    logic [DATA_W-1:0] lat_interval_reg, lat_interval_next;
    logic [DATA_W-1:0] lat_width_reg, lat_width_next;
    logic              lat_level_reg, lat_level_next;
    logic [DATA_W-1:0] late_reg, late_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] rsh_reg, rsh_next;
    logic              c_age_reg, c_age_next;    // borrow of now - began
    logic              c_cmp_reg, c_cmp_next;    // borrow of age - width
    logic              c_late_reg, c_late_next;  // borrow of now - deadline / now - rem
    logic              c_sum_reg, c_sum_next;    // carry of now + interval / + interval
    logic              c_wvi_reg, c_wvi_next;    // borrow of width - interval
    logic              inz_reg, inz_next;        // interval nonzero
    logic              wnz_reg, wnz_next;        // width nonzero

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // bit-level cells
    logic              n0, b0, i0, w0;
    logic              age_bit, sub_y, late_bit, add_x, sum_bit;
    logic              is_add, last_bit, carry_run;
    logic [DATA_W-1:0] now_rot, interval_rot, sum_full, late_full;
    logic [DATA_W-1:0] began_rot, deadline_rot, width_rot;
    logic              fin_ge, fin_reached, fin_ok;
    logic              catch_up;

    assign n0 = now_reg[0];
    assign b0 = began_reg[0];
    assign i0 = lat_interval_reg[0];
    assign w0 = lat_width_reg[0];

    assign is_add    = (state_reg == S_ADD);
    assign last_bit  = (cnt_reg == BIT_LAST);
    assign carry_run = (state_reg == S_SER) || is_add;

    // now - began, then compared against the latched width
    assign age_bit    = n0 ^ b0 ^ c_age_reg;
    assign c_age_next = (~n0 & b0) | (~(n0 ^ b0) & c_age_reg);
    assign c_cmp_next = (~age_bit & w0) | (~(age_bit ^ w0) & c_cmp_reg);

    // serial subtractor: now - deadline while scanning, now - remainder in the add pass
    assign sub_y       = is_add ? rsh_reg[0] : deadline_reg[0];
    assign late_bit    = n0 ^ sub_y ^ c_late_reg;
    assign c_late_next = (~n0 & sub_y) | (~(n0 ^ sub_y) & c_late_reg);

    // serial adder: now + interval while scanning, (now - rem) + interval after
    assign add_x      = is_add ? late_bit : n0;
    assign sum_bit    = add_x ^ i0 ^ c_sum_reg;
    assign c_sum_next = (add_x & i0) | (add_x & c_sum_reg) | (i0 & c_sum_reg);

    // width < interval
    assign c_wvi_next = (~w0 & i0) | (~(w0 ^ i0) & c_wvi_reg);
    assign inz_next   = inz_reg | i0;
    assign wnz_next   = wnz_reg | w0;

    assign now_rot      = {now_reg[0], now_reg[DATA_W-1:1]};
    assign interval_rot = {lat_interval_reg[0], lat_interval_reg[DATA_W-1:1]};
    assign began_rot    = {began_reg[0], began_reg[DATA_W-1:1]};
    assign deadline_rot = {deadline_reg[0], deadline_reg[DATA_W-1:1]};
    assign width_rot    = {lat_width_reg[0], lat_width_reg[DATA_W-1:1]};
    assign sum_full     = {sum_bit, sum_reg[DATA_W-1:1]};
    assign late_full    = {late_bit, late_reg[DATA_W-1:1]};

    // flags valid on the last scan bit
    assign fin_ge      = ~c_cmp_next;
    assign fin_reached = ~late_bit;
    assign fin_ok      = inz_next & wnz_next & c_wvi_next;

    // poll paths that move the deadline forward by whole intervals
    always_comb
    begin
        catch_up = 1'b0;
        if (op_reg == OP_POLL && running_reg && fin_reached)
        begin
            if (!pulsing_reg || fin_ge)
                catch_up = 1'b1;
        end
    end

    // Sequencer. The scan pass rotates every operand once; on its last bit
    // the flags are complete and the opcode is resolved. A catch-up poll then
    // needs late mod interval: new deadline = now - rem + interval.
    always_comb
    begin
        state_next        = state_reg;
        pulsing_next      = pulsing_reg;
        running_next      = running_reg;
        pin_state_next    = pin_state_reg;
        accepted_next     = accepted_reg;
        cnt_next          = cnt_reg;
        op_next           = op_reg;
        now_next          = now_reg;
        began_next        = began_reg;
        deadline_next     = deadline_reg;
        lat_interval_next = lat_interval_reg;
        lat_width_next    = lat_width_reg;
        lat_level_next    = lat_level_reg;
        late_next         = late_reg;
        sum_next          = sum_reg;
        rsh_next          = rsh_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = late_full;
        div_req.divisor   = interval_rot;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode_t'(opcode);
                    now_next = now_ms;
                    cnt_next = '0;
                    // start samples the settings before the scan uses them
                    if (opcode_t'(opcode) == OP_START)
                    begin
                        lat_interval_next = feed_interval_reg;
                        lat_width_next    = pulse_width_reg;
                        lat_level_next    = active_high_reg;
                    end
                    state_next = S_SER;
                end
            end

            S_SER:
            begin
                cnt_next          = cnt_reg + 1'b1;
                now_next          = now_rot;
                began_next        = began_rot;
                deadline_next     = deadline_rot;
                lat_interval_next = interval_rot;
                lat_width_next    = width_rot;
                late_next         = late_full;
                sum_next          = sum_full;
                if (last_bit)
                begin
                    accepted_next = 1'b0;
                    state_next    = S_OUT;
                    case (op_reg)
                        OP_START:
                        begin
                            // bad settings still load deadline and start time
                            pulsing_next  = 1'b0;
                            running_next  = fin_ok;
                            deadline_next = sum_full;
                            began_next    = now_rot;
                            if (fin_ok)
                                pin_state_next = ~lat_level_reg;
                        end
                        OP_POLL:
                        begin
                            if (running_reg)
                            begin
                                if (pulsing_reg)
                                begin
                                    if (fin_ge)
                                    begin
                                        pin_state_next = ~lat_level_reg;
                                        pulsing_next   = 1'b0;
                                    end
                                end
                                else if (fin_reached)
                                begin
                                    pin_state_next = lat_level_reg;
                                    pulsing_next   = 1'b1;
                                    began_next     = now_rot;
                                end
                            end
                            if (catch_up)
                            begin
                                div_req.start = 1'b1;
                                state_next    = S_DIV;
                            end
                        end
                        OP_FORCE:
                        begin
                            // only while enabled and not pulsing; deadline restarts one interval out
                            if (running_reg && !pulsing_reg)
                            begin
                                pin_state_next = lat_level_reg;
                                pulsing_next   = 1'b1;
                                began_next     = now_rot;
                                deadline_next  = sum_full;
                                accepted_next  = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            if (running_reg)
                                pin_state_next = ~lat_level_reg;
                            pulsing_next = 1'b0;
                            running_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    rsh_next   = div_rsp.rem;
                    cnt_next   = '0;
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                cnt_next          = cnt_reg + 1'b1;
                now_next          = now_rot;
                lat_interval_next = interval_rot;
                rsh_next          = {1'b0, rsh_reg[DATA_W-1:1]};
                sum_next          = sum_full;
                if (last_bit)
                begin
                    deadline_next = sum_full;
                    state_next    = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // settings port; index 3 is not a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_interval_reg <= INTERVAL_RST;
            pulse_width_reg   <= PULSE_RST;
            active_high_reg   <= LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_INTERVAL: feed_interval_reg <= cfg_data;
                CFG_WIDTH:    pulse_width_reg   <= cfg_data;
                CFG_LEVEL:    active_high_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pulsing_reg      <= 1'b0;
            running_reg      <= 1'b0;
            pin_state_reg    <= 1'b0;
            accepted_reg     <= 1'b0;
            cnt_reg          <= '0;
            op_reg           <= OP_POLL;
            now_reg          <= '0;
            began_reg        <= '0;
            deadline_reg     <= '0;
            lat_interval_reg <= '0;
            lat_width_reg    <= '0;
            lat_level_reg    <= 1'b0;
            late_reg         <= '0;
            sum_reg          <= '0;
            rsh_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pulsing_reg      <= pulsing_next;
            running_reg      <= running_next;
            pin_state_reg    <= pin_state_next;
            accepted_reg     <= accepted_next;
            cnt_reg          <= cnt_next;
            op_reg           <= op_next;
            now_reg          <= now_next;
            began_reg        <= began_next;
            deadline_reg     <= deadline_next;
            lat_interval_reg <= lat_interval_next;
            lat_width_reg    <= lat_width_next;
            lat_level_reg    <= lat_level_next;
            late_reg         <= late_next;
            sum_reg          <= sum_next;
            rsh_reg          <= rsh_next;
        end
    end

    // carries and flags run only during a pass and start clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_age_reg  <= 1'b0;
            c_cmp_reg  <= 1'b0;
            c_late_reg <= 1'b0;
            c_sum_reg  <= 1'b0;
            c_wvi_reg  <= 1'b0;
            inz_reg    <= 1'b0;
            wnz_reg    <= 1'b0;
        end
        else if (carry_run)
        begin
            c_age_reg  <= c_age_next;
            c_cmp_reg  <= c_cmp_next;
            c_late_reg <= c_late_next;
            c_sum_reg  <= c_sum_next;
            c_wvi_reg  <= c_wvi_next;
            inz_reg    <= inz_next;
            wnz_reg    <= wnz_next;
        end
        else
        begin
            c_age_reg  <= 1'b0;
            c_cmp_reg  <= 1'b0;
            c_late_reg <= 1'b0;
            c_sum_reg  <= 1'b0;
            c_wvi_reg  <= 1'b0;
            inz_reg    <= 1'b0;
            wnz_reg    <= 1'b0;
        end
    end

    wfps_rem_div u_rem_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign pin_level      = pin_state_reg;
    assign pulse_active   = pulsing_reg;
    assign enabled_flag   = running_reg;
    assign force_accepted = accepted_reg;

endmodule

### rtl/wfps_rem_div.sv
// ============================================================================
// wfps_rem_div: restoring remainder unit
// One dividend bit per cycle; done is registered and pulses in the cycle after the last bit.
// ============================================================================
module wfps_rem_div
    import wfps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;

    assign shifted = {rem_reg, dvd_reg[DATA_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shifted is below twice the divisor, so one subtract restores
            if (shifted >= {1'b0, dvs_reg})
                rem_next = DATA_W'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[DATA_W-1:0];
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### rtl/wfps_checker.sv
// ============================================================================
// wfps_checker: port-level checks for the watchdog feed pulse scheduler
// Attached to the top level through a bind statement.
// ============================================================================
module wfps_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pulse_active,
    input logic enabled_flag,
    input logic force_accepted
);

    // a stalled result stays offered
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            out_valid && out_stall |=> out_valid;
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result withdrawn while stalled");

    // one result per item: a taken result is not offered again at once
    property p_single_result;
        @(posedge clk) disable iff (!rst_n)
            out_valid && !out_stall |=> !out_valid;
    endproperty
    a_single_result: assert property (p_single_result)
        else $error("result repeated after transfer");

    // an accepted item needs the serial pass before any result shows
    property p_no_instant_result;
        @(posedge clk) disable iff (!rst_n)
            in_valid && !in_stall |=> !out_valid;
    endproperty
    a_no_instant_result: assert property (p_no_instant_result)
        else $error("result shown right after input transfer");

    // a pulse only runs while enabled, and an accepted force leaves one running
    property p_pulse_needs_enable;
        @(posedge clk) disable iff (!rst_n)
            out_valid && (pulse_active || force_accepted) |-> enabled_flag;
    endproperty
    a_pulse_needs_enable: assert property (p_pulse_needs_enable)
        else $error("pulse reported while disabled");

    property p_force_pulses;
        @(posedge clk) disable iff (!rst_n)
            out_valid && force_accepted |-> pulse_active;
    endproperty
    a_force_pulses: assert property (p_force_pulses)
        else $error("accepted force without a pulse");

endmodule

bind watchdog_feed_pulse_scheduler wfps_checker u_wfps_checker (.*);
